// ===== design/tgad_pkg.sv =====
// ----------------------------------------------------------------------------
// TGA stream decoder package
// Header layout, image type codes, error codes, parser phases, result word.
// ----------------------------------------------------------------------------
package tgad_pkg;

  localparam int unsigned HEADER_LEN = 18;

  // byte offsets inside the header
  localparam logic [4:0] HDR_ID_LEN    = 5'd0;
  localparam logic [4:0] HDR_TYPE      = 5'd2;
  localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
  localparam logic [4:0] HDR_BPP       = 5'd16;
  localparam logic [4:0] HDR_DESC      = 5'd17;

  localparam logic [7:0] TYPE_TRUECOLOR = 8'd2;
  localparam logic [7:0] TYPE_GRAY      = 8'd3;
  localparam logic [7:0] ORIGIN_BIT     = 8'h20;

  localparam logic [7:0] BPP_8  = 8'd8;
  localparam logic [7:0] BPP_24 = 8'd24;
  localparam logic [7:0] BPP_32 = 8'd32;

  localparam logic [2:0] CH_GRAY = 3'd1;
  localparam logic [2:0] CH_RGB  = 3'd3;
  localparam logic [2:0] CH_RGBA = 3'd4;

  typedef enum logic [1:0] {
    ERR_NONE        = 2'd0,
    ERR_SMALL       = 2'd1,
    ERR_UNSUPPORTED = 2'd2,
    ERR_TRUNCATED   = 2'd3
  } err_t;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_ID     = 4'b0010,
    PH_PIXELS = 4'b0100,
    PH_DRAIN  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic        kind;
    err_t        error_code;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [2:0]  channels;
    logic        last;
  } res_t;

  function automatic res_t err_word(err_t code);
    res_t r;
    r            = '0;
    r.kind       = 1'b1;
    r.error_code = code;
    r.last       = 1'b1;
    return r;
  endfunction

endpackage

// ===== design/tga_uncompressed_stream_decoder_top.sv =====
// ----------------------------------------------------------------------------
// TGA uncompressed stream decoder
// Parses header, skips id field, emits RGB(A)/gray pixels and error words.
// ----------------------------------------------------------------------------
// Each result word is registered into the result queue when its byte is accepted.
// Throughput: one byte per cycle while in_ready is high; a byte that causes
// a pixel and an error word fills two entries of a three-entry result queue,
// so in_ready drops for one cycle after it even with out_ready held high.
// in_ready is high while at most one result word is queued.
// Reset (rst_n low, synchronous) returns the parser to the header phase and
// empties the result queue.
module tga_uncompressed_stream_decoder_top
  import tgad_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [1:0]  out_error_code,
  output logic [15:0] out_pixel_x,
  output logic [15:0] out_pixel_y,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic [2:0]  out_channels,
  output logic        out_last
);

  // parser state
  phase_t      phase_r, phase_nxt;
  logic [4:0]  hidx_r, hidx_nxt;
  logic [7:0]  id_left_r, id_left_nxt;
  logic        gray_r, gray_nxt;
  logic        type_ok_r, type_ok_nxt;
  logic [7:0]  bpp_r, bpp_nxt;
  logic [15:0] width_r, width_nxt;
  logic [15:0] height_r, height_nxt;
  logic        top_left_r, top_left_nxt;
  logic [15:0] col_r, col_nxt;
  logic [15:0] row_r, row_nxt;
  logic [1:0]  bip_r, bip_nxt;
  logic [23:0] held_r, held_nxt;

  // result queue
  res_t        slot_r [3];
  res_t        slot_nxt [3];
  logic [1:0]  cnt_r, cnt_nxt;

  logic        push, pop;
  logic [1:0]  n_res;
  res_t        res0, res1;

  logic        hdr_ok;
  logic [23:0] held_upd;
  logic [4:0]  bip_inc;
  logic [2:0]  ch;
  logic        final_px;
  logic [15:0] col_inc;
  logic [15:0] y_pix;
  logic [1:0]  cnt_p;

  assign in_ready  = (cnt_r <= 2'd1);
  assign push      = in_valid && in_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && out_ready;

  assign hdr_ok = type_ok_r && (width_r != 16'd0) && (height_r != 16'd0) &&
                  (bpp_r == BPP_8 || bpp_r == BPP_24 || bpp_r == BPP_32) &&
                  !(!gray_r && bpp_r == BPP_8);

  assign ch       = gray_r ? CH_GRAY : ((bpp_r == BPP_32) ? CH_RGBA : CH_RGB);
  assign bip_inc  = {3'd0, bip_r} + 5'd1;
  assign final_px = ({1'b0, col_r} + 17'd1 == {1'b0, width_r}) &&
                    ({1'b0, row_r} + 17'd1 == {1'b0, height_r});
  assign col_inc  = col_r + 16'd1;
  assign y_pix    = top_left_r ? row_r : (height_r - 16'd1 - row_r);

  always_comb begin
    case (bip_r)
      2'd0:    held_upd = held_r | {16'd0, in_data_byte};
      2'd1:    held_upd = held_r | {8'd0, in_data_byte, 8'd0};
      2'd2:    held_upd = held_r | {in_data_byte, 16'd0};
      default: held_upd = held_r;
    endcase
  end

  always_comb begin
    phase_nxt    = phase_r;
    hidx_nxt     = hidx_r;
    id_left_nxt  = id_left_r;
    gray_nxt     = gray_r;
    type_ok_nxt  = type_ok_r;
    bpp_nxt      = bpp_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    top_left_nxt = top_left_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    bip_nxt      = bip_r;
    held_nxt     = held_r;
    n_res        = 2'd0;
    res0         = err_word(ERR_TRUNCATED);
    res1         = err_word(ERR_TRUNCATED);

    case (phase_r)
      PH_HEADER: begin
        case (hidx_r)
          HDR_ID_LEN:    id_left_nxt = in_data_byte;
          HDR_TYPE: begin
            gray_nxt    = (in_data_byte == TYPE_GRAY);
            type_ok_nxt = (in_data_byte == TYPE_TRUECOLOR) ||
                          (in_data_byte == TYPE_GRAY);
          end
          HDR_WIDTH_LO:  width_nxt  = {width_r[15:8], in_data_byte};
          HDR_WIDTH_HI:  width_nxt  = {in_data_byte, width_r[7:0]};
          HDR_HEIGHT_LO: height_nxt = {height_r[15:8], in_data_byte};
          HDR_HEIGHT_HI: height_nxt = {in_data_byte, height_r[7:0]};
          HDR_BPP:       bpp_nxt    = in_data_byte;
          HDR_DESC:      top_left_nxt = ((in_data_byte & ORIGIN_BIT) != 8'd0);
          default: ;
        endcase
        if (hidx_r != HDR_DESC) begin
          hidx_nxt = hidx_r + 5'd1;
          if (in_end_of_file) begin
            n_res = 2'd1;
            res0  = err_word(ERR_SMALL);
          end
        end else if (!hdr_ok) begin
          n_res     = 2'd1;
          res0      = err_word(ERR_UNSUPPORTED);
          phase_nxt = PH_DRAIN;
        end else begin
          phase_nxt = (id_left_r != 8'd0) ? PH_ID : PH_PIXELS;
          if (in_end_of_file) n_res = 2'd1;
        end
      end
      PH_ID: begin
        id_left_nxt = id_left_r - 8'd1;
        if (id_left_nxt == 8'd0) phase_nxt = PH_PIXELS;
        if (in_end_of_file) n_res = 2'd1;
      end
      PH_PIXELS: begin
        held_nxt = held_upd;
        if (bip_inc < bpp_r[7:3]) begin
          bip_nxt = bip_inc[1:0];
          if (in_end_of_file) n_res = 2'd1;
        end else begin
          res0            = '0;
          res0.error_code = ERR_NONE;
          res0.pixel_x    = col_r;
          res0.pixel_y    = y_pix;
          res0.channels   = ch;
          res0.last       = final_px;
          if (ch == CH_GRAY) begin
            res0.red = held_upd[7:0];
          end else begin
            res0.red   = held_upd[23:16];
            res0.green = held_upd[15:8];
            res0.blue  = held_upd[7:0];
            res0.alpha = (ch == CH_RGBA) ? in_data_byte : 8'd0;
          end
          n_res    = 2'd1;
          bip_nxt  = 2'd0;
          held_nxt = 24'd0;
          if (final_px) begin
            phase_nxt = PH_DRAIN;
          end else begin
            if (col_inc == width_r) begin
              col_nxt = 16'd0;
              row_nxt = row_r + 16'd1;
            end else begin
              col_nxt = col_inc;
            end
            if (in_end_of_file) n_res = 2'd2;
          end
        end
      end
      default: ; // drain: byte ignored
    endcase

    if (in_end_of_file) begin
      phase_nxt    = PH_HEADER;
      hidx_nxt     = 5'd0;
      id_left_nxt  = 8'd0;
      gray_nxt     = 1'b0;
      type_ok_nxt  = 1'b0;
      bpp_nxt      = 8'd0;
      width_nxt    = 16'd0;
      height_nxt   = 16'd0;
      top_left_nxt = 1'b0;
      col_nxt      = 16'd0;
      row_nxt      = 16'd0;
      bip_nxt      = 2'd0;
      held_nxt     = 24'd0;
    end
  end

  // queue: shift out the head on pop, then append new words behind the rest
  always_comb begin
    cnt_p       = cnt_r - {1'b0, pop};
    slot_nxt[0] = pop ? slot_r[1] : slot_r[0];
    slot_nxt[1] = pop ? slot_r[2] : slot_r[1];
    slot_nxt[2] = slot_r[2];
    cnt_nxt     = cnt_p;
    if (push) begin
      cnt_nxt = cnt_p + n_res;
      for (int i = 0; i < 3; i++) begin
        if (n_res != 2'd0 && cnt_p == i[1:0]) slot_nxt[i] = res0;
        if (n_res == 2'd2 && cnt_p + 2'd1 == i[1:0]) slot_nxt[i] = res1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      hidx_r     <= 5'd0;
      id_left_r  <= 8'd0;
      gray_r     <= 1'b0;
      type_ok_r  <= 1'b0;
      bpp_r      <= 8'd0;
      width_r    <= 16'd0;
      height_r   <= 16'd0;
      top_left_r <= 1'b0;
      col_r      <= 16'd0;
      row_r      <= 16'd0;
      bip_r      <= 2'd0;
      held_r     <= 24'd0;
      cnt_r      <= 2'd0;
    end else begin
      if (push) begin
        phase_r    <= phase_nxt;
        hidx_r     <= hidx_nxt;
        id_left_r  <= id_left_nxt;
        gray_r     <= gray_nxt;
        type_ok_r  <= type_ok_nxt;
        bpp_r      <= bpp_nxt;
        width_r    <= width_nxt;
        height_r   <= height_nxt;
        top_left_r <= top_left_nxt;
        col_r      <= col_nxt;
        row_r      <= row_nxt;
        bip_r      <= bip_nxt;
        held_r     <= held_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) slot_r[i] <= slot_nxt[i];
  end

  assign out_kind       = slot_r[0].kind;
  assign out_error_code = slot_r[0].error_code;
  assign out_pixel_x    = slot_r[0].pixel_x;
  assign out_pixel_y    = slot_r[0].pixel_y;
  assign out_red        = slot_r[0].red;
  assign out_green      = slot_r[0].green;
  assign out_blue       = slot_r[0].blue;
  assign out_alpha      = slot_r[0].alpha;
  assign out_channels   = slot_r[0].channels;
  assign out_last       = slot_r[0].last;

  a_eof_resets: assert property (@(posedge clk) disable iff (!rst_n)
    push && in_end_of_file |=> phase_r == PH_HEADER && hidx_r == 5'd0 && bip_r == 2'd0)
    else $error("parser not back in header phase after end of file");

  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind |-> out_last && out_channels == 3'd0 &&
    out_pixel_x == 16'd0 && out_error_code != ERR_NONE)
    else $error("malformed error word");

  a_pix_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_kind |-> out_error_code == ERR_NONE && out_channels != 3'd0)
    else $error("malformed pixel word");

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// TGA uncompressed stream decoder testbench
// Sends whole and cut-short TGA files byte by byte. A local decoder tracks the
// parser state and queues the expected pixel and error words. Each word taken
// from the block is checked field by field against the oldest queued word.
// ----------------------------------------------------------------------------
module tb_top;
  import tgad_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int TAIL_CYCLES  = 10;
  localparam int LONG_HOLD    = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = '0;
  logic        in_end_of_file = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_kind;
  logic [1:0]  out_error_code;
  logic [15:0] out_pixel_x;
  logic [15:0] out_pixel_y;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_alpha;
  logic [2:0]  out_channels;
  logic        out_last;

  tga_uncompressed_stream_decoder_top DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // decoder state mirror
  phase_t      ph;
  logic [4:0]  hdr_idx;
  logic [7:0]  id_left;
  logic        is_gray;
  logic        type_ok;
  logic [7:0]  bpp;
  logic [15:0] img_w;
  logic [15:0] img_h;
  logic        top_left;
  logic [15:0] col;
  logic [15:0] row;
  logic [1:0]  byte_k;
  logic [23:0] held;

  res_t decoded_q[$];

  int  mismatches = 0;
  int  bytes_sent = 0;
  int  cycle_cnt = 0;
  bit  src_gaps = 1'b1;
  bit  sink_gaps = 1'b1;
  int  hold_req = 0;
  int  hold_seen = 0;
  int  hold_cnt = 0;
  int  stall_cnt = 0;

  function automatic void clear_parser();
    ph      = PH_HEADER;
    hdr_idx = '0;
    id_left = '0;
    is_gray = 1'b0;
    type_ok = 1'b0;
    bpp     = '0;
    img_w   = '0;
    img_h   = '0;
    top_left = 1'b0;
    col     = '0;
    row     = '0;
    byte_k  = '0;
    held    = '0;
  endfunction

  function automatic void push_error(err_t code);
    res_t r;
    r            = '0;
    r.kind       = 1'b1;
    r.error_code = code;
    r.last       = 1'b1;
    decoded_q.push_back(r);
  endfunction

  // advance the mirror by one accepted byte and queue the words it causes
  function automatic void decode_byte(logic [7:0] b, logic eof);
    res_t       r;
    logic [7:0] nbytes;
    logic       final_px;
    logic       ok;
    case (ph)
      PH_HEADER: begin
        case (hdr_idx)
          HDR_ID_LEN:    id_left = b;
          HDR_TYPE: begin
            is_gray = (b == TYPE_GRAY);
            type_ok = (b == TYPE_GRAY) || (b == TYPE_TRUECOLOR);
          end
          HDR_WIDTH_LO:  img_w[7:0] = b;
          HDR_WIDTH_HI:  img_w[15:8] = b;
          HDR_HEIGHT_LO: img_h[7:0] = b;
          HDR_HEIGHT_HI: img_h[15:8] = b;
          HDR_BPP:       bpp = b;
          HDR_DESC:      top_left = (b & ORIGIN_BIT) != 0;
          default: ;
        endcase
        if (int'(hdr_idx) + 1 < HEADER_LEN) begin
          hdr_idx = hdr_idx + 5'd1;
          if (eof) push_error(ERR_SMALL);
        end else begin
          ok = type_ok && img_w != 0 && img_h != 0 &&
               (bpp == BPP_8 || bpp == BPP_24 || bpp == BPP_32) &&
               !(!is_gray && bpp == BPP_8);
          if (!ok) begin
            push_error(ERR_UNSUPPORTED);
            ph = PH_DRAIN;
          end else begin
            ph = (id_left != 0) ? PH_ID : PH_PIXELS;
            if (eof) push_error(ERR_TRUNCATED);
          end
        end
      end
      PH_ID: begin
        id_left = id_left - 8'd1;
        if (id_left == 0) ph = PH_PIXELS;
        if (eof) push_error(ERR_TRUNCATED);
      end
      PH_PIXELS: begin
        nbytes = bpp >> 3;
        if (byte_k < 2'd3) held = held | (24'(b) << (8 * byte_k));
        if (int'(byte_k) + 1 < int'(nbytes)) begin
          byte_k = byte_k + 2'd1;
          if (eof) push_error(ERR_TRUNCATED);
        end else begin
          final_px     = (int'(col) + 1 == int'(img_w)) && (int'(row) + 1 == int'(img_h));
          r            = '0;
          r.kind       = 1'b0;
          r.error_code = ERR_NONE;
          r.pixel_x    = col;
          r.pixel_y    = top_left ? row : img_h - 16'd1 - row;
          if (is_gray) begin
            r.channels = CH_GRAY;
            r.red      = held[7:0];
          end else begin
            r.channels = (bpp == BPP_32) ? CH_RGBA : CH_RGB;
            r.red      = held[23:16];
            r.green    = held[15:8];
            r.blue     = held[7:0];
            r.alpha    = (bpp == BPP_32) ? b : 8'd0;
          end
          r.last = final_px;
          decoded_q.push_back(r);
          byte_k = '0;
          held   = '0;
          if (final_px) begin
            ph = PH_DRAIN;
          end else begin
            col = col + 16'd1;
            if (col == img_w) begin
              col = '0;
              row = row + 16'd1;
            end
            if (eof) push_error(ERR_TRUNCATED);
          end
        end
      end
      default: ;  // drain: byte ignored
    endcase
    if (eof) clear_parser();
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] ERROR %s: got %0h expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic cmp_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) flag_mismatch(what, got, want);
  endtask

  // ---- result side ----
  always @(posedge clk) begin : check_words
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (decoded_q.size() == 0) begin
        flag_mismatch("word with nothing pending", out_kind, 0);
      end else begin
        want = decoded_q.pop_front();
        cmp_field("kind", out_kind, want.kind);
        cmp_field("error_code", out_error_code, want.error_code);
        cmp_field("pixel_x", out_pixel_x, want.pixel_x);
        cmp_field("pixel_y", out_pixel_y, want.pixel_y);
        cmp_field("red", out_red, want.red);
        cmp_field("green", out_green, want.green);
        cmp_field("blue", out_blue, want.blue);
        cmp_field("alpha", out_alpha, want.alpha);
        cmp_field("channels", out_channels, want.channels);
        cmp_field("last", out_last, want.last);
      end
    end
  end

  // ready: long hold-off on request, else short random stalls
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_cnt  = LONG_HOLD;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt--;
      out_ready <= 1'b0;
    end else if (sink_gaps && $urandom_range(0, 4) == 0) begin
      stall_cnt = $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---- input side ----
  // called and returns at a falling edge
  task automatic send_byte(logic [7:0] b, logic eof);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid       = 1'b1;
    in_data_byte   = b;
    in_end_of_file = eof;
    do @(posedge clk); while (!in_ready);
    decode_byte(b, eof);
    bytes_sent++;
    @(negedge clk);
  endtask

  // one file: header, id field, random pixel bytes, trailing bytes;
  // cut > 0 below the full length ends the file after that many bytes
  task automatic send_file(logic [7:0] id_len, logic [7:0] img_type, logic [15:0] w,
                           logic [15:0] h, logic [7:0] pix_bits, logic [7:0] desc,
                           int cut, int extra);
    logic [7:0] hdr [HEADER_LEN];
    longint     total;
    longint     len;
    logic [7:0] b;
    for (int i = 0; i < HEADER_LEN; i++) hdr[i] = 8'($urandom_range(0, 255));
    hdr[HDR_ID_LEN]    = id_len;
    hdr[HDR_TYPE]      = img_type;
    hdr[HDR_WIDTH_LO]  = w[7:0];
    hdr[HDR_WIDTH_HI]  = w[15:8];
    hdr[HDR_HEIGHT_LO] = h[7:0];
    hdr[HDR_HEIGHT_HI] = h[15:8];
    hdr[HDR_BPP]       = pix_bits;
    hdr[HDR_DESC]      = desc;
    total = HEADER_LEN + id_len + longint'(w) * h * (pix_bits >> 3) + extra;
    len   = (cut > 0 && cut < total) ? cut : total;
    for (longint i = 0; i < len; i++) begin
      b = (i < HEADER_LEN) ? hdr[i] : 8'($urandom_range(0, 255));
      send_byte(b, i == len - 1);
    end
  endtask

  // ---- tests ----
  task automatic test_short_header();
    send_file(0, TYPE_GRAY, 2, 2, BPP_8, 0, 1, 0);
    send_file(0, TYPE_GRAY, 2, 2, BPP_8, 0, 17, 0);
    send_file(3, TYPE_TRUECOLOR, 1, 1, BPP_24, 0, $urandom_range(2, 16), 0);
  endtask

  task automatic test_unsupported();
    send_file(0, 8'd1, 2, 2, BPP_24, 0, 21, 0);
    send_file(0, TYPE_TRUECOLOR, 2, 2, BPP_8, 0, 20, 0);
    send_file(0, TYPE_GRAY, 0, 2, BPP_8, 0, 19, 0);
    send_file(0, TYPE_GRAY, 2, 0, BPP_8, 0, 19, 0);
    send_file(0, TYPE_TRUECOLOR, 1, 1, 8'd16, 0, 0, 2);
    send_file(0, 8'd10, 1, 1, BPP_32, 0, 18, 0);
    send_file(0, 8'hFF, 1, 1, 8'hFF, 8'hFF, 22, 0);
    send_file(1, TYPE_TRUECOLOR, 1, 1, 8'd0, 0, 0, 3);
  endtask

  task automatic test_truncation();
    send_file(0, TYPE_GRAY, 2, 2, BPP_8, 0, 18, 0);
    send_file(4, TYPE_GRAY, 2, 2, BPP_8, 0, 18, 0);
    send_file(5, TYPE_TRUECOLOR, 2, 2, BPP_24, 0, 21, 0);
    send_file(5, TYPE_TRUECOLOR, 2, 2, BPP_24, 0, 23, 0);
    send_file(0, TYPE_TRUECOLOR, 2, 2, BPP_24, 0, 22, 0);
    // eof lands on the byte that completes a non-final pixel
    send_file(0, TYPE_TRUECOLOR, 2, 2, BPP_24, ORIGIN_BIT, 24, 0);
    send_file(0, TYPE_GRAY, 3, 1, BPP_32, 0, 26, 0);
  endtask

  task automatic test_formats();
    send_file(0, TYPE_GRAY, 1, 1, BPP_8, 8'h00, 0, 0);
    send_file(0, TYPE_GRAY, 3, 2, BPP_24, ORIGIN_BIT, 0, 0);
    send_file(2, TYPE_GRAY, 2, 2, BPP_32, 8'h00, 0, 2);
    send_file(1, TYPE_TRUECOLOR, 2, 3, BPP_24, 8'hDF, 0, 0);
    send_file(0, TYPE_TRUECOLOR, 3, 2, BPP_32, 8'hFF, 0, 3);
    send_file(8'hFF, TYPE_GRAY, 1, 2, BPP_8, ORIGIN_BIT, 0, 0);
    // full-scale dimensions, cut after a few pixels
    send_file(0, TYPE_GRAY, 16'hFFFF, 16'hFFFF, BPP_8, 8'h00, 23, 0);
    send_file(0, TYPE_TRUECOLOR, 16'hFFFF, 16'hFFFF, BPP_32, ORIGIN_BIT, 27, 0);
    send_file(0, TYPE_TRUECOLOR, 16'hFFFF, 1, BPP_24, 8'h00, 30, 0);
  endtask

  task automatic test_backpressure();
    src_gaps = 1'b0;
    @(posedge clk);
    hold_req++;
    @(negedge clk);
    send_file(0, TYPE_GRAY, 8, 8, BPP_8, 0, 0, 0);
    src_gaps = 1'b1;
  endtask

  task automatic test_random_files(int count);
    int         target;
    int         full;
    int         cut;
    int         extra;
    logic [7:0] id_len;
    logic [7:0] img_type;
    logic [7:0] pix_bits;
    logic [15:0] w;
    logic [15:0] h;
    target = bytes_sent + count;
    while (bytes_sent < target) begin
      if ($urandom_range(0, 19) < 16) begin
        if ($urandom_range(0, 1) == 1) begin
          img_type = TYPE_GRAY;
          case ($urandom_range(0, 2))
            0:       pix_bits = BPP_8;
            1:       pix_bits = BPP_24;
            default: pix_bits = BPP_32;
          endcase
        end else begin
          img_type = TYPE_TRUECOLOR;
          pix_bits = $urandom_range(0, 1) ? BPP_32 : BPP_24;
        end
        w      = 16'($urandom_range(1, 6));
        h      = 16'($urandom_range(1, 4));
        id_len = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 12)) : 8'd0;
        extra  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        full   = HEADER_LEN + id_len + w * h * (pix_bits >> 3) + extra;
        cut    = ($urandom_range(0, 4) == 0) ? $urandom_range(1, full) : 0;
        send_file(id_len, img_type, w, h, pix_bits, 8'($urandom_range(0, 255)), cut, extra);
      end else begin
        // noise: loose header fields, file ended at a random length of at most 40 bytes
        img_type = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, 3));
        case ($urandom_range(0, 5))
          0:       pix_bits = 8'd0;
          1:       pix_bits = BPP_8;
          2:       pix_bits = 8'd16;
          3:       pix_bits = BPP_24;
          4:       pix_bits = BPP_32;
          default: pix_bits = 8'($urandom_range(0, 255));
        endcase
        send_file(8'($urandom_range(0, 3)), img_type, 16'($urandom_range(0, 3)),
                  16'($urandom_range(0, 3)), pix_bits, 8'($urandom_range(0, 255)),
                  $urandom_range(1, 40), 0);
      end
    end
  endtask

  initial begin
    clear_parser();
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    test_short_header();
    test_unsupported();
    test_truncation();
    test_formats();
    test_backpressure();
    test_random_files(500);
    // closing stretch with both sides running flat out
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    test_random_files(250);
    in_valid = 1'b0;

    while (decoded_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
